// ----- rtl/core/nfae_pkg.sv -----
// Shared types and constants for the n-body force accumulator.
`timescale 1ns / 1ps
package nfae_pkg;

  localparam int VALUE_WIDTH_DEF  = 48;
  localparam int FRAC_BITS_DEF    = 24;
  localparam int NEWTON_STEPS_DEF = 4;

  localparam int MASS_W      = 32;
  localparam int CFG_W       = 32;
  localparam int CFG_INDEX_W = 1;
  localparam int MODE_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int STEP_FRAC   = 24;
  localparam int RSH_W       = 10;

  localparam logic [31:0] STEP_SIZE_RST  = 32'd16777216;
  localparam logic [31:0] GRAV_CONST_RST = 32'd0;

  // 1.5 in Q2.30
  localparam logic [63:0] THREE_HALVES = 64'd3 << 29;
  // Newton seeds, Q2.30
  localparam logic [63:0] SEED_LO = 64'd27 << 25;
  localparam logic [63:0] SEED_HI = 64'd19 << 25;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_STEP_SIZE  = 1'd0,
    CFG_GRAV_CONST = 1'd1
  } cfg_index_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_ADD   = 2'd2,
    MODE_STEP  = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_COINCIDENT = 2'd1,
    ST_SAT        = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCALE, S_MUL, S_WAIT, S_NORM, S_PNORM, S_SCL, S_ACC, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    STP_SQ_A, STP_SQ_B, STP_NT_Y2, STP_NT_T, STP_NT_Y, STP_Y2, STP_Y3,
    STP_GM, STP_PM, STP_FX, STP_FY, STP_VX, STP_VY, STP_PX, STP_PY
  } step_t;

  typedef struct packed {
    logic    idle;
    logic    res_valid;
    status_t status;
  } core_stat_t;

endpackage

// ----- rtl/core/nfae_mul.sv -----
// Shared 64x64 multiplier built from one 32x32 multiplier over four partial products.
`timescale 1ns / 1ps
module nfae_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  op_a,
  input  logic [63:0]  op_b,
  output logic         done,
  output logic [127:0] prod
);

  logic [63:0]  a;
  logic [63:0]  b;
  logic [2:0]   cnt;
  logic         busy;
  logic [63:0]  pp;
  logic [1:0]   pp_sel;
  logic         pp_vld;
  logic [127:0] acc;
  logic [31:0]  sel_a;
  logic [31:0]  sel_b;
  logic [127:0] pp_shifted;
  logic         issue;

  assign issue = busy && !cnt[2];

  always_comb begin
    sel_a = cnt[1] ? a[63:32] : a[31:0];
    sel_b = (cnt[1:0] == 2'd1 || cnt[1:0] == 2'd3) ? b[63:32] : b[31:0];
  end

  always_comb begin
    unique case (pp_sel)
      2'd0:    pp_shifted = {64'd0, pp};
      2'd1,
      2'd2:    pp_shifted = {32'd0, pp, 32'd0};
      default: pp_shifted = {pp, 64'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      cnt    <= 3'd0;
      pp_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      done   <= pp_vld && (pp_sel == 2'd3);
      pp_vld <= issue;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
      end else if (issue) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd3) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a   <= op_a;
      b   <= op_b;
      acc <= '0;
    end
    if (issue) begin
      pp     <= sel_a * sel_b;
      pp_sel <= cnt[1:0];
    end
    if (pp_vld) acc <= acc + pp_shifted;
  end

  assign prod = acc;

endmodule

// ----- rtl/core/nfae_core.sv -----
// Sequencer and datapath: body state, pull computation and Euler step on the shared multiplier.
`timescale 1ns / 1ps
module nfae_core #(
  parameter int VALUE_WIDTH  = nfae_pkg::VALUE_WIDTH_DEF,
  parameter int FRAC_BITS    = nfae_pkg::FRAC_BITS_DEF,
  parameter int NEWTON_STEPS = nfae_pkg::NEWTON_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [nfae_pkg::MODE_W-1:0]     mode,
  input  logic [nfae_pkg::MASS_W-1:0]     mass,
  input  logic signed [VALUE_WIDTH-1:0]   in_x,
  input  logic signed [VALUE_WIDTH-1:0]   in_y,
  input  logic signed [VALUE_WIDTH-1:0]   in_vx,
  input  logic signed [VALUE_WIDTH-1:0]   in_vy,
  input  logic [nfae_pkg::CFG_W-1:0]      step_size,
  input  logic [nfae_pkg::CFG_W-1:0]      grav_const,
  input  logic                            res_ready,
  output nfae_pkg::core_stat_t            stat,
  output logic signed [VALUE_WIDTH-1:0]   pos_x,
  output logic signed [VALUE_WIDTH-1:0]   pos_y,
  output logic signed [VALUE_WIDTH-1:0]   vel_x,
  output logic signed [VALUE_WIDTH-1:0]   vel_y,
  output logic signed [VALUE_WIDTH-1:0]   force_x,
  output logic signed [VALUE_WIDTH-1:0]   force_y
);

  localparam int VW = VALUE_WIDTH;
  localparam int KW = $clog2(VALUE_WIDTH + 1);
  localparam int IW = $clog2(NEWTON_STEPS + 1);
  localparam int RW = nfae_pkg::RSH_W;
  localparam logic [63:0] VMAX = 64'((65'd1 << (VALUE_WIDTH - 1)) - 65'd1);

  nfae_pkg::state_t st, st_next;
  nfae_pkg::step_t  stp;

  logic           mul_start;
  logic           mul_done;
  logic [127:0]   mul_prod;
  logic [63:0]    op_a;
  logic [63:0]    op_b;
  logic           op_neg;

  logic [VW-1:0]  ax, ay, a2, b2;
  logic           nx, ny;
  logic [KW-1:0]  k;
  logic [63:0]    r2;
  logic signed [7:0] sh;
  logic [31:0]    m;
  logic [63:0]    y, y2, h, gm;
  logic [127:0]   p;
  logic [6:0]     s;
  logic signed [RW-1:0] rsh, rsh_calc;
  logic [IW-1:0]  iter;
  logic [nfae_pkg::MASS_W-1:0] mass_q;
  logic           coin, sat;
  logic signed [VW-1:0] d;
  logic [VW:0]    post;
  logic [VW:0]    acc_res;
  logic signed [VW-1:0] acc_tgt;
  logic [VW:0]    dfx, dfy;
  logic [32:0]    t_val;
  logic           over;
  logic           norm_ok;

  function automatic logic [VW-1:0] mag_of(input logic signed [VW-1:0] v);
    return v[VW-1] ? VW'(-v) : VW'(v);
  endfunction

  // {neg, magnitude} of other - own
  function automatic logic [VW:0] diff(input logic signed [VW-1:0] other,
                                       input logic signed [VW-1:0] own);
    logic signed [VW:0] dv;
    dv = {other[VW-1], other} - {own[VW-1], own};
    return dv[VW] ? {1'b1, VW'(-dv)} : {1'b0, dv[VW-1:0]};
  endfunction

  // {sat, value}: product scaled by 2^-r, truncated, clamped, signed
  function automatic logic [VW:0] scale_post(input logic [127:0] pr,
                                             input logic signed [RW-1:0] r,
                                             input logic neg);
    logic [63:0]    cap;
    logic [63:0]    res;
    logic [127:0]   q;
    logic [RW-1:0]  nr;
    logic           sf;
    logic [VW-1:0]  v;
    cap = neg ? VMAX + 64'd1 : VMAX;
    sf  = 1'b0;
    res = '0;
    q   = '0;
    nr  = RW'(-r);
    if (!r[RW-1]) begin
      q = (r >= RW'(128)) ? '0 : (pr >> r[6:0]);
      if (q[127:64] != 64'd0 || q[63:0] > cap) begin
        res = cap;
        sf  = 1'b1;
      end else begin
        res = q[63:0];
      end
    end else if (pr == '0) begin
      res = '0;
    end else if (pr[127:64] != 64'd0 || nr >= RW'(64) || pr[63:0] > (cap >> nr[5:0])) begin
      res = cap;
      sf  = 1'b1;
    end else begin
      res = pr[63:0] << nr[5:0];
    end
    v = VW'(res);
    if (neg) v = -v;
    return {sf, v};
  endfunction

  function automatic logic [VW:0] sat_add(input logic signed [VW-1:0] a,
                                          input logic signed [VW-1:0] b);
    logic signed [VW:0] sm;
    sm = {a[VW-1], a} + {b[VW-1], b};
    if (sm[VW] != sm[VW-1])
      return {1'b1, sm[VW], {(VW-1){~sm[VW]}}};
    return {1'b0, sm[VW-1:0]};
  endfunction

  nfae_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .op_a  (op_a),
    .op_b  (op_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign dfx     = diff(in_x, pos_x);
  assign dfy     = diff(in_y, pos_y);
  assign over    = (((a2 | b2) >> 31) != '0);
  assign norm_ok = (r2[63:32] == 32'd0) && (r2[31:30] != 2'd0);
  assign t_val   = mul_prod[63:31];
  assign post    = scale_post(mul_prod, rsh, op_neg);
  assign acc_res = sat_add(acc_tgt, d);

  always_comb begin
    logic signed [RW-1:0] eh;
    eh = RW'(k) + RW'(sh >>> 1) + RW'(15) - RW'(FRAC_BITS);
    rsh_calc = RW'(78) + RW'(3) * eh - RW'(s);
  end

  // Operand select for the shared multiplier
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_neg = 1'b0;
    unique case (stp)
      nfae_pkg::STP_SQ_A:  begin op_a = 64'(a2); op_b = 64'(a2); end
      nfae_pkg::STP_SQ_B:  begin op_a = 64'(b2); op_b = 64'(b2); end
      nfae_pkg::STP_NT_Y2: begin op_a = y; op_b = y; end
      nfae_pkg::STP_NT_T:  begin op_a = 64'(m); op_b = y2; end
      nfae_pkg::STP_NT_Y:  begin op_a = y; op_b = h; end
      nfae_pkg::STP_Y2:    begin op_a = y; op_b = y; end
      nfae_pkg::STP_Y3:    begin op_a = y2; op_b = y; end
      nfae_pkg::STP_GM:    begin op_a = 64'(grav_const); op_b = 64'(mass_q); end
      nfae_pkg::STP_PM:    begin op_a = gm; op_b = h; end
      nfae_pkg::STP_FX:    begin op_a = 64'(ax); op_b = p[63:0]; op_neg = nx; end
      nfae_pkg::STP_FY:    begin op_a = 64'(ay); op_b = p[63:0]; op_neg = ny; end
      nfae_pkg::STP_VX: begin
        op_a = 64'(mag_of(force_x)); op_b = 64'(step_size); op_neg = force_x[VW-1];
      end
      nfae_pkg::STP_VY: begin
        op_a = 64'(mag_of(force_y)); op_b = 64'(step_size); op_neg = force_y[VW-1];
      end
      nfae_pkg::STP_PX: begin
        op_a = 64'(mag_of(vel_x)); op_b = 64'(step_size); op_neg = vel_x[VW-1];
      end
      nfae_pkg::STP_PY: begin
        op_a = 64'(mag_of(vel_y)); op_b = 64'(step_size); op_neg = vel_y[VW-1];
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (stp)
      nfae_pkg::STP_FX: acc_tgt = force_x;
      nfae_pkg::STP_FY: acc_tgt = force_y;
      nfae_pkg::STP_VX: acc_tgt = vel_x;
      nfae_pkg::STP_VY: acc_tgt = vel_y;
      nfae_pkg::STP_PX: acc_tgt = pos_x;
      default:          acc_tgt = pos_y;
    endcase
  end

  // Next state
  always_comb begin
    st_next = st;
    unique case (st)
      nfae_pkg::S_IDLE: begin
        if (start) begin
          unique case (nfae_pkg::mode_t'(mode))
            nfae_pkg::MODE_LOAD,
            nfae_pkg::MODE_CLEAR: st_next = nfae_pkg::S_DONE;
            nfae_pkg::MODE_ADD:   st_next = nfae_pkg::S_SCALE;
            nfae_pkg::MODE_STEP:  st_next = nfae_pkg::S_MUL;
          endcase
        end
      end
      nfae_pkg::S_SCALE: begin
        if (ax == '0 && ay == '0) st_next = nfae_pkg::S_DONE;
        else if (!over)           st_next = nfae_pkg::S_MUL;
      end
      nfae_pkg::S_MUL: st_next = nfae_pkg::S_WAIT;
      nfae_pkg::S_WAIT: begin
        if (mul_done) begin
          priority case (stp)
            nfae_pkg::STP_SQ_B: st_next = nfae_pkg::S_NORM;
            nfae_pkg::STP_PM:   st_next = nfae_pkg::S_PNORM;
            nfae_pkg::STP_FX, nfae_pkg::STP_FY, nfae_pkg::STP_VX,
            nfae_pkg::STP_VY, nfae_pkg::STP_PX, nfae_pkg::STP_PY:
                                st_next = nfae_pkg::S_SCL;
            default:            st_next = nfae_pkg::S_MUL;
          endcase
        end
      end
      nfae_pkg::S_NORM:  if (norm_ok) st_next = nfae_pkg::S_MUL;
      nfae_pkg::S_PNORM: if (p[127:64] == 64'd0) st_next = nfae_pkg::S_MUL;
      nfae_pkg::S_SCL:   st_next = nfae_pkg::S_ACC;
      nfae_pkg::S_ACC: begin
        if (stp == nfae_pkg::STP_FY || stp == nfae_pkg::STP_PY) st_next = nfae_pkg::S_DONE;
        else st_next = nfae_pkg::S_MUL;
      end
      nfae_pkg::S_DONE:  if (res_ready) st_next = nfae_pkg::S_IDLE;
      default:           st_next = nfae_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    mul_start      = (st == nfae_pkg::S_MUL);
    stat.idle      = (st == nfae_pkg::S_IDLE);
    stat.res_valid = (st == nfae_pkg::S_DONE);
    if (coin)     stat.status = nfae_pkg::ST_COINCIDENT;
    else if (sat) stat.status = nfae_pkg::ST_SAT;
    else          stat.status = nfae_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= nfae_pkg::S_IDLE;
      pos_x   <= '0;
      pos_y   <= '0;
      vel_x   <= '0;
      vel_y   <= '0;
      force_x <= '0;
      force_y <= '0;
      coin    <= 1'b0;
      sat     <= 1'b0;
    end else begin
      st <= st_next;
      if (st == nfae_pkg::S_IDLE && start) begin
        coin <= 1'b0;
        sat  <= 1'b0;
        unique case (nfae_pkg::mode_t'(mode))
          nfae_pkg::MODE_LOAD: begin
            pos_x <= in_x;
            pos_y <= in_y;
            vel_x <= in_vx;
            vel_y <= in_vy;
          end
          nfae_pkg::MODE_CLEAR: begin
            force_x <= '0;
            force_y <= '0;
          end
          nfae_pkg::MODE_ADD,
          nfae_pkg::MODE_STEP: ;
        endcase
      end
      if (st == nfae_pkg::S_SCALE && ax == '0 && ay == '0) coin <= 1'b1;
      if (st == nfae_pkg::S_SCL && post[VW]) sat <= 1'b1;
      if (st == nfae_pkg::S_ACC) begin
        if (acc_res[VW]) sat <= 1'b1;
        unique case (stp)
          nfae_pkg::STP_FX: force_x <= acc_res[VW-1:0];
          nfae_pkg::STP_FY: force_y <= acc_res[VW-1:0];
          nfae_pkg::STP_VX: vel_x   <= acc_res[VW-1:0];
          nfae_pkg::STP_VY: vel_y   <= acc_res[VW-1:0];
          nfae_pkg::STP_PX: pos_x   <= acc_res[VW-1:0];
          default:          pos_y   <= acc_res[VW-1:0];
        endcase
      end
    end
  end

  // Working registers, no reset needed
  always_ff @(posedge clk) begin
    priority case (st)
      nfae_pkg::S_IDLE: begin
        if (start) begin
          {nx, ax} <= dfx;
          {ny, ay} <= dfy;
          a2       <= dfx[VW-1:0];
          b2       <= dfy[VW-1:0];
          k        <= '0;
          mass_q   <= mass;
          rsh      <= RW'(nfae_pkg::STEP_FRAC);
          stp      <= (nfae_pkg::mode_t'(mode) == nfae_pkg::MODE_STEP) ?
                      nfae_pkg::STP_VX : nfae_pkg::STP_SQ_A;
        end
      end
      nfae_pkg::S_SCALE: begin
        // drop one bit until both fit in 31 bits
        if (over) begin
          a2 <= a2 >> 1;
          b2 <= b2 >> 1;
          k  <= k + KW'(1);
        end
      end
      nfae_pkg::S_WAIT: begin
        if (mul_done) begin
          priority case (stp)
            nfae_pkg::STP_SQ_A: begin
              r2  <= mul_prod[63:0];
              stp <= nfae_pkg::STP_SQ_B;
            end
            nfae_pkg::STP_SQ_B: begin
              r2 <= r2 + mul_prod[63:0];
              sh <= '0;
            end
            nfae_pkg::STP_NT_Y2: begin
              y2  <= 64'(mul_prod[63:30]);
              stp <= nfae_pkg::STP_NT_T;
            end
            nfae_pkg::STP_NT_T: begin
              h   <= (64'(t_val) >= nfae_pkg::THREE_HALVES) ? 64'd0 :
                     nfae_pkg::THREE_HALVES - 64'(t_val);
              stp <= nfae_pkg::STP_NT_Y;
            end
            nfae_pkg::STP_NT_Y: begin
              y    <= 64'(mul_prod[63:30]);
              iter <= iter + IW'(1);
              stp  <= (iter == IW'(NEWTON_STEPS - 1)) ? nfae_pkg::STP_Y2 : nfae_pkg::STP_NT_Y2;
            end
            nfae_pkg::STP_Y2: begin
              y2  <= 64'(mul_prod[63:30]);
              stp <= nfae_pkg::STP_Y3;
            end
            nfae_pkg::STP_Y3: begin
              h   <= 64'(mul_prod[63:30]);
              stp <= nfae_pkg::STP_GM;
            end
            nfae_pkg::STP_GM: begin
              gm  <= mul_prod[63:0];
              stp <= nfae_pkg::STP_PM;
            end
            nfae_pkg::STP_PM: begin
              p <= mul_prod;
              s <= '0;
            end
            default: ;
          endcase
        end
      end
      nfae_pkg::S_NORM: begin
        // bring r2 into [2^30, 2^32) two bits at a time
        if (r2[63:32] != 32'd0) begin
          r2 <= r2 >> 2;
          sh <= sh + 8'sd2;
        end else if (r2[31:30] == 2'd0) begin
          r2 <= r2 << 2;
          sh <= sh - 8'sd2;
        end else begin
          m    <= r2[31:0];
          y    <= r2[31] ? nfae_pkg::SEED_HI : nfae_pkg::SEED_LO;
          iter <= '0;
          stp  <= nfae_pkg::STP_NT_Y2;
        end
      end
      nfae_pkg::S_PNORM: begin
        if (p[127:64] != 64'd0) begin
          p <= p >> 1;
          s <= s + 7'd1;
        end else begin
          rsh <= rsh_calc;
          stp <= nfae_pkg::STP_FX;
        end
      end
      nfae_pkg::S_SCL: begin
        d <= post[VW-1:0];
      end
      nfae_pkg::S_ACC: begin
        unique case (stp)
          nfae_pkg::STP_FX: stp <= nfae_pkg::STP_FY;
          nfae_pkg::STP_VX: stp <= nfae_pkg::STP_VY;
          nfae_pkg::STP_VY: stp <= nfae_pkg::STP_PX;
          nfae_pkg::STP_PX: stp <= nfae_pkg::STP_PY;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  a_mul_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (st == nfae_pkg::S_WAIT))
    else $error("multiplier finished outside wait state");

  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    (st == nfae_pkg::S_NORM && st_next == nfae_pkg::S_MUL) |=> (m[31:30] != 2'd0))
    else $error("mantissa not normalized");

  a_coin_holds_force: assert property (@(posedge clk) disable iff (rst)
    (st == nfae_pkg::S_SCALE && ax == '0 && ay == '0) |=>
      ($stable(force_x) && $stable(force_y)))
    else $error("coincident body changed the force");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (st == nfae_pkg::S_DONE && !res_ready) |=>
      (st == nfae_pkg::S_DONE && $stable(pos_x) && $stable(force_y)))
    else $error("result dropped before taken");

  a_sat_flag: assert property (@(posedge clk) disable iff (rst)
    (st == nfae_pkg::S_SCL && post[VW]) |=> sat)
    else $error("saturation not flagged");

endmodule

// ----- rtl/core/nbody_force_accumulate_euler.sv -----
// Top level: stream ports, configuration registers and result register.
`timescale 1ns / 1ps
// One 2-D body under direct-sum gravity with a semi-implicit Euler step. Each input
// beat carries a mode in tuser: load position and velocity, clear the force, add the
// pull of one other body, or integrate one step; each beat gives one result beat with
// the full body state and a status (ok, coincident body skipped, saturated). Load and
// clear go straight to the done state. An Euler step runs four products on the
// multiplier, each followed by a scale and an accumulate step, then the done state.
// Adding a pull runs 20 products on the single 32x32 multiplier (four partial
// products each), plus bit-serial normalize loops whose length depends on the
// distance and the product size; a coincident body goes from the scale state
// straight to done. One item is worked at a time; a finished result waits in the
// output register while the next item is taken.
module nbody_force_accumulate_euler #(
  parameter int VALUE_WIDTH  = nfae_pkg::VALUE_WIDTH_DEF,
  parameter int FRAC_BITS    = nfae_pkg::FRAC_BITS_DEF,
  parameter int NEWTON_STEPS = nfae_pkg::NEWTON_STEPS_DEF,
  localparam int IN_DATA_W   = ((nfae_pkg::MASS_W + 4 * VALUE_WIDTH + 7) / 8) * 8,
  localparam int OUT_DATA_W  = ((6 * VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // in_mass, in_x, in_y, in_vx, in_vy
  input  logic [IN_DATA_W-1:0]                s_axis_tdata,
  // mode
  input  logic [nfae_pkg::MODE_W-1:0]         s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_x, out_y, out_vx, out_vy, out_fx, out_fy
  output logic [OUT_DATA_W-1:0]               m_axis_tdata,
  // status
  output logic [nfae_pkg::STATUS_W-1:0]       m_axis_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nfae_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [nfae_pkg::CFG_W-1:0]          cfg_data
);

  localparam int VW = VALUE_WIDTH;
  localparam int MW = nfae_pkg::MASS_W;

  logic [nfae_pkg::CFG_W-1:0] step_size;
  logic [nfae_pkg::CFG_W-1:0] grav_const;
  nfae_pkg::core_stat_t       stat;
  logic                       res_ready;
  logic signed [VW-1:0]       pos_x, pos_y, vel_x, vel_y, force_x, force_y;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = stat.idle;
  assign res_ready     = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size  <= nfae_pkg::STEP_SIZE_RST;
      grav_const <= nfae_pkg::GRAV_CONST_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (nfae_pkg::cfg_index_t'(cfg_index))
        nfae_pkg::CFG_STEP_SIZE:  step_size  <= cfg_data;
        nfae_pkg::CFG_GRAV_CONST: grav_const <= cfg_data;
      endcase
    end
  end

  nfae_core #(
    .VALUE_WIDTH  (VALUE_WIDTH),
    .FRAC_BITS    (FRAC_BITS),
    .NEWTON_STEPS (NEWTON_STEPS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .start      (s_axis_tvalid && s_axis_tready),
    .mode       (s_axis_tuser),
    .mass       (s_axis_tdata[MW-1:0]),
    .in_x       (s_axis_tdata[MW +: VW]),
    .in_y       (s_axis_tdata[MW + VW +: VW]),
    .in_vx      (s_axis_tdata[MW + 2*VW +: VW]),
    .in_vy      (s_axis_tdata[MW + 3*VW +: VW]),
    .step_size  (step_size),
    .grav_const (grav_const),
    .res_ready  (res_ready),
    .stat       (stat),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .vel_x      (vel_x),
    .vel_y      (vel_y),
    .force_x    (force_x),
    .force_y    (force_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= stat.res_valid;
    end
  end

  // hold the beat until taken
  always_ff @(posedge clk) begin
    if (res_ready && stat.res_valid) begin
      m_axis_tdata <= OUT_DATA_W'({force_y, force_x, vel_y, vel_x, pos_y, pos_x});
      m_axis_tuser <= stat.status;
    end
  end

endmodule

// ----- dv/nbody_force_accumulate_euler_chk.sv -----
// Checker for the n-body force accumulator: predicts every result beat and compares it.
`timescale 1ns / 1ps
module nbody_force_accumulate_euler_chk (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [223:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [287:0] m_axis_tdata,
  input  logic [1:0]   m_axis_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           errors,
  output int           pending
);

  localparam longint VMAX = (64'sd1 <<< 47) - 1;
  localparam longint VMIN = -VMAX - 1;

  typedef struct {
    logic [47:0]       x, y, vx, vy, fx, fy;
    nfae_pkg::status_t st;
  } body_state_t;

  longint      px, py, vx, vy, fx, fy;
  bit [63:0]   step_h, grav_g;
  body_state_t expected_q[$];

  function automatic int msb_count(bit [63:0] v);
    int n;
    n = 0;
    for (int i = 0; i < 64; i++) if (v[i]) n = i + 1;
    return n;
  endfunction

  // magnitude times m2, scaled by 2^-r, truncated and clamped, then signed
  function automatic longint scaled_prod(bit [63:0] mag, bit neg, bit [63:0] m2, int r,
                                         inout bit sat);
    bit [127:0] p, q;
    bit [63:0]  cap, res;
    int         n;
    p   = {64'd0, mag} * {64'd0, m2};
    cap = neg ? 64'(VMAX) + 1 : 64'(VMAX);
    if (r >= 0) begin
      q = (r >= 128) ? 128'd0 : p >> r;
      if (q[127:64] != 0 || q[63:0] > cap) begin
        res = cap;
        sat = 1;
      end else begin
        res = q[63:0];
      end
    end else begin
      n = -r;
      if (p == 0) res = 0;
      else if (p[127:64] != 0 || n >= 64 || p[63:0] > (cap >> n)) begin
        res = cap;
        sat = 1;
      end else begin
        res = p[63:0] << n;
      end
    end
    return neg ? -longint'(res) : longint'(res);
  endfunction

  function automatic longint clamp_add(longint a, longint b, inout bit sat);
    longint s;
    s = a + b;
    if (s > VMAX) begin
      sat = 1;
      return VMAX;
    end
    if (s < VMIN) begin
      sat = 1;
      return VMIN;
    end
    return s;
  endfunction

  function automatic longint vmag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // returns 1 for a coincident body
  function automatic bit add_gravity(bit [63:0] mass, longint ox, longint oy, inout bit sat);
    bit [63:0]  ax, ay, a2, b2, r2, m, y, y2, t, h, y3;
    bit         nx, ny;
    int         n, k, len, sh, e, s, r;
    bit [127:0] p;
    nx = ox < px;
    ny = oy < py;
    ax = nx ? px - ox : ox - px;
    ay = ny ? py - oy : oy - py;
    if (ax == 0 && ay == 0) return 1;
    n  = msb_count(ax > ay ? ax : ay);
    k  = n > 31 ? n - 31 : 0;
    a2 = ax >> k;
    b2 = ay >> k;
    r2 = a2 * a2 + b2 * b2;
    len = msb_count(r2);
    sh = len - 31;
    if (sh % 2 != 0) sh = len - 32;
    m = sh >= 0 ? r2 >> sh : r2 << (-sh);
    y = (m < (64'd1 << 31)) ? nfae_pkg::SEED_LO : nfae_pkg::SEED_HI;
    for (int i = 0; i < nfae_pkg::NEWTON_STEPS_DEF; i++) begin
      y2 = (y * y) >> 30;
      t  = (m * y2) >> 31;
      h  = t >= nfae_pkg::THREE_HALVES ? 64'd0 : nfae_pkg::THREE_HALVES - t;
      y  = (y * h) >> 30;
    end
    y2 = (y * y) >> 30;
    y3 = (y2 * y) >> 30;
    e = 2 * k + sh + 30 - 2 * nfae_pkg::FRAC_BITS_DEF;
    p = {64'd0, grav_g * mass} * {64'd0, y3};
    s = msb_count(p[127:64]);
    p = p >> s;
    r = 78 + 3 * (e / 2) - s;
    fx = clamp_add(fx, scaled_prod(ax, nx, p[63:0], r, sat), sat);
    fy = clamp_add(fy, scaled_prod(ay, ny, p[63:0], r, sat), sat);
    return 0;
  endfunction

  function automatic body_state_t apply_beat(nfae_pkg::mode_t mode, logic [223:0] d);
    bit                sat;
    nfae_pkg::status_t st;
    body_state_t       o;
    sat = 0;
    st  = nfae_pkg::ST_OK;
    case (mode)
      nfae_pkg::MODE_LOAD: begin
        px = longint'($signed(d[79:32]));
        py = longint'($signed(d[127:80]));
        vx = longint'($signed(d[175:128]));
        vy = longint'($signed(d[223:176]));
      end
      nfae_pkg::MODE_CLEAR: begin
        fx = 0;
        fy = 0;
      end
      nfae_pkg::MODE_ADD: begin
        if (add_gravity({32'd0, d[31:0]}, longint'($signed(d[79:32])),
                        longint'($signed(d[127:80])), sat))
          st = nfae_pkg::ST_COINCIDENT;
      end
      default: begin
        vx = clamp_add(vx, scaled_prod(vmag(fx), fx < 0, step_h, nfae_pkg::STEP_FRAC, sat),
                       sat);
        vy = clamp_add(vy, scaled_prod(vmag(fy), fy < 0, step_h, nfae_pkg::STEP_FRAC, sat),
                       sat);
        px = clamp_add(px, scaled_prod(vmag(vx), vx < 0, step_h, nfae_pkg::STEP_FRAC, sat),
                       sat);
        py = clamp_add(py, scaled_prod(vmag(vy), vy < 0, step_h, nfae_pkg::STEP_FRAC, sat),
                       sat);
      end
    endcase
    if (st == nfae_pkg::ST_OK && sat) st = nfae_pkg::ST_SAT;
    o.x  = px[47:0];
    o.y  = py[47:0];
    o.vx = vx[47:0];
    o.vy = vy[47:0];
    o.fx = fx[47:0];
    o.fy = fy[47:0];
    o.st = st;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    $display("MISMATCH %0t %s: got %h, want %h", $time, what, got, want);
    errors++;
  endtask

  assign pending = expected_q.size();

  always @(posedge clk) begin
    body_state_t e;
    if (rst) begin
      errors = 0;
      px = 0; py = 0; vx = 0; vy = 0; fx = 0; fy = 0;
      step_h = {32'd0, nfae_pkg::STEP_SIZE_RST};
      grav_g = {32'd0, nfae_pkg::GRAV_CONST_RST};
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == nfae_pkg::CFG_STEP_SIZE) step_h = {32'd0, cfg_data};
        else grav_g = {32'd0, cfg_data};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result beat, x", m_axis_tdata[47:0], 48'd0);
        end else begin
          e = expected_q.pop_front();
          if (m_axis_tdata[47:0] !== e.x) report_mismatch("x", m_axis_tdata[47:0], e.x);
          if (m_axis_tdata[95:48] !== e.y) report_mismatch("y", m_axis_tdata[95:48], e.y);
          if (m_axis_tdata[143:96] !== e.vx)
            report_mismatch("vx", m_axis_tdata[143:96], e.vx);
          if (m_axis_tdata[191:144] !== e.vy)
            report_mismatch("vy", m_axis_tdata[191:144], e.vy);
          if (m_axis_tdata[239:192] !== e.fx)
            report_mismatch("fx", m_axis_tdata[239:192], e.fx);
          if (m_axis_tdata[287:240] !== e.fy)
            report_mismatch("fy", m_axis_tdata[287:240], e.fy);
          if (m_axis_tuser !== e.st) report_mismatch("status", 48'(m_axis_tuser), 48'(e.st));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(apply_beat(nfae_pkg::mode_t'(s_axis_tuser), s_axis_tdata));
    end
  end

endmodule

// ----- dv/nbody_force_accumulate_euler_tb.sv -----
// Testbench top: clock, reset, stimulus and verdict for the n-body force accumulator.
`timescale 1ns / 1ps
module nbody_force_accumulate_euler_tb;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [223:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [287:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [0:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;
  int           errors, pending;
  int           idle_pct = 0, stall_pct = 0;
  logic [47:0]  own_x = '0, own_y = '0;

  localparam logic [47:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] POS_MIN = 48'h8000_0000_0000;

  always #10 clk = ~clk;

  nbody_force_accumulate_euler uut (.*);

  nbody_force_accumulate_euler_chk chk (.*);

  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  task automatic send_beat(nfae_pkg::mode_t mode, logic [31:0] mass, logic [47:0] x,
                           logic [47:0] y, logic [47:0] vx, logic [47:0] vy);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {vy, vx, y, x, mass};
    if (mode == nfae_pkg::MODE_LOAD) begin
      own_x = x;
      own_y = y;
    end
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  task automatic write_reg(nfae_pkg::cfg_index_t idx, logic [31:0] val);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [47:0] rnd48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic logic [47:0] any_value();
    case ($urandom_range(4))
      0: return rnd48();
      1: return $urandom_range(1) ? POS_MAX - $urandom_range(3) : POS_MIN + $urandom_range(3);
      2: return 48'($signed($urandom_range(2000)) - 1000);
      default: return 48'($signed({$urandom, $urandom} >>> $urandom_range(16, 56)));
    endcase
  endfunction

  // other body near the loaded one so the pull lands in range
  function automatic logic [47:0] near(logic [47:0] c);
    case ($urandom_range(4))
      0: return c;
      1: return rnd48();
      default: return c + 48'($signed({$urandom, $urandom} >>> $urandom_range(14, 60)));
    endcase
  endfunction

  function automatic logic [31:0] any_word();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
      1: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_body();
    int adds;
    send_beat(nfae_pkg::MODE_LOAD, $urandom, any_value(), any_value(), any_value(),
              any_value());
    if ($urandom_range(3) != 0) send_beat(nfae_pkg::MODE_CLEAR, $urandom, rnd48(), rnd48(),
                                          rnd48(), rnd48());
    adds = $urandom_range(0, 5);
    repeat (adds) send_beat(nfae_pkg::MODE_ADD, any_word(), near(own_x), near(own_y),
                            rnd48(), rnd48());
    repeat ($urandom_range(1, 3)) send_beat(nfae_pkg::MODE_STEP, $urandom, rnd48(), rnd48(),
                                            rnd48(), rnd48());
  endtask

  task automatic run_noise();
    send_beat(nfae_pkg::mode_t'($urandom_range(3)), any_word(), any_value(), any_value(),
              any_value(), any_value());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, extremes, coincident body, saturation
    send_beat(nfae_pkg::MODE_STEP, '0, '0, '0, '0, '0);
    send_beat(nfae_pkg::MODE_ADD, 32'hFFFF_FFFF, 48'd5, 48'd7, '0, '0);
    send_beat(nfae_pkg::MODE_LOAD, '0, POS_MAX, POS_MIN, POS_MAX, POS_MIN);
    send_beat(nfae_pkg::MODE_STEP, '0, '0, '0, '0, '0);
    send_beat(nfae_pkg::MODE_LOAD, '0, '0, '0, 48'h0000_0100_0000, 48'hFFFF_FF00_0000);
    send_beat(nfae_pkg::MODE_STEP, '0, '0, '0, '0, '0);
    write_reg(nfae_pkg::CFG_GRAV_CONST, 32'hFFFF_FFFF);
    send_beat(nfae_pkg::MODE_ADD, 32'hFFFF_FFFF, own_x, own_y, '0, '0);
    send_beat(nfae_pkg::MODE_ADD, 32'h0001_0000, 48'h0000_0100_0000, own_y, '0, '0);
    send_beat(nfae_pkg::MODE_ADD, 32'hFFFF_FFFF, own_x + 48'd1, own_y, '0, '0);
    send_beat(nfae_pkg::MODE_ADD, 32'hFFFF_FFFF, POS_MIN, POS_MAX, '0, '0);
    send_beat(nfae_pkg::MODE_ADD, 32'd1, POS_MAX, POS_MAX, '0, '0);
    send_beat(nfae_pkg::MODE_STEP, '0, '0, '0, '0, '0);
    write_reg(nfae_pkg::CFG_STEP_SIZE, 32'hFFFF_FFFF);
    send_beat(nfae_pkg::MODE_STEP, '0, '0, '0, '0, '0);
    send_beat(nfae_pkg::MODE_CLEAR, 32'hFFFF_FFFF, POS_MAX, POS_MAX, POS_MAX, POS_MAX);
    write_reg(nfae_pkg::CFG_STEP_SIZE, 32'd0);
    send_beat(nfae_pkg::MODE_LOAD, '0, POS_MIN, POS_MAX, POS_MIN, POS_MAX);
    send_beat(nfae_pkg::MODE_ADD, 32'h0010_0000, 48'd0, 48'd0, '0, '0);
    send_beat(nfae_pkg::MODE_STEP, '0, '0, '0, '0, '0);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 47; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 47; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      write_reg(nfae_pkg::CFG_STEP_SIZE,
                ph == 3 ? 32'hFFFF_FFFF : ph == 5 ? 32'd0 : any_word());
      write_reg(nfae_pkg::CFG_GRAV_CONST,
                ph == 6 ? 32'd0 : ph == 2 ? 32'hFFFF_FFFF : any_word());
      // leave some stretches with no idling in every phase
      for (int i = 0; i < 40; i++) begin
        if (i == 30) begin
          idle_pct = 0;
          stall_pct = 0;
        end
        if ($urandom_range(9) == 0) run_noise();
        else run_body();
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0)
      $display("nbody_force_accumulate_euler verification clean");
    else
      $display("nbody_force_accumulate_euler verification failed");
    $finish;
  end

  initial begin
    #60ms;
    $display("nbody_force_accumulate_euler verification failed");
    $finish;
  end

endmodule
